// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jeti_pkg.sv =====
// Shared types, constants and helper functions of the escape-time iterator.
`default_nettype none
package jeti_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int PIXEL_BITS_DEF = 12;
  localparam int ITER_BITS_DEF  = 16;

  localparam int VAL_W     = 32;
  localparam int STEP_W    = 31;
  localparam int LIMIT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 64;
  localparam int SAT_W     = 66;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP       = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SETUP,
    ST_RADIUS,
    ST_UPDATE,
    ST_MULT
  } state_t;

  typedef enum logic [1:0] {
    MUL_MAP,
    MUL_KI,
    MUL_Z
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_BOUNDED,
    RES_ESC_NOW,
    RES_ESC_PREV
  } res_kind_t;

  typedef struct packed {
    mul_sel_t  mul_sel;
    logic      load_pixel;
    logic      load_z;
    logic      load_radius;
    logic      update_z;
    logic      finish;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic mag_over;
    logic overflow;
  } status_t;

  function automatic logic sat_ovf(input logic signed [SAT_W-1:0] v);
    sat_ovf = !((&v[SAT_W-1:VAL_W-1]) || !(|v[SAT_W-1:VAL_W-1]));
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
    if (!sat_ovf(v)) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[SAT_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/julia_escape_time_iterator.sv =====
// Top level of the Julia and parameter-plane escape-time iterator.
// A pixel word is taken at a rising edge where start is high and busy is low;
// busy then stays high until the orbit is finished, and the result word is
// shown for exactly one cycle with done high, the cycle in which busy has
// dropped again, so a new start may be taken in that same cycle. The receiver
// cannot stall the result. Each orbit step runs through a multiply register
// and a square-add update, so every iteration of the z recurrence passes
// through ST_UPDATE and then ST_MULT.
// Configuration writes are to be made only while busy is low and no result
// is pending.
`default_nettype none
module julia_escape_time_iterator import jeti_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PIXEL_BITS-1:0] pixel_x,
  input  wire logic [PIXEL_BITS-1:0] pixel_y,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [VAL_W-1:0]      cfg_data,
  output logic                       done,
  output logic [PIXEL_BITS-1:0]      out_x,
  output logic [PIXEL_BITS-1:0]      out_y,
  output logic                       escaped,
  output logic [ITER_BITS-1:0]       escape_iteration
);

  logic                    mode;
  logic [LIMIT_W-1:0]      max_iterations;
  logic signed [VAL_W-1:0] const_real;
  logic signed [VAL_W-1:0] const_imag;
  logic signed [VAL_W-1:0] left_edge;
  logic [STEP_W-1:0]       column_step;
  logic signed [VAL_W-1:0] top_edge;
  logic [STEP_W-1:0]       row_step;

  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b0;
      max_iterations <= LIMIT_RESET;
      const_real     <= '0;
      const_imag     <= '0;
      left_edge      <= '0;
      column_step    <= '0;
      top_edge       <= '0;
      row_step       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:           mode           <= cfg_data[0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[LIMIT_W-1:0];
        REG_CONST_REAL:     const_real     <= cfg_data;
        REG_CONST_IMAG:     const_imag     <= cfg_data;
        REG_LEFT_EDGE:      left_edge      <= cfg_data;
        REG_COLUMN_STEP:    column_step    <= cfg_data[STEP_W-1:0];
        REG_TOP_EDGE:       top_edge       <= cfg_data;
        REG_ROW_STEP:       row_step       <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  jeti_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  jeti_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .mode             (mode),
    .max_iterations   (max_iterations),
    .const_real       (const_real),
    .const_imag       (const_imag),
    .left_edge        (left_edge),
    .column_step      (column_step),
    .top_edge         (top_edge),
    .row_step         (row_step),
    .out_x            (out_x),
    .out_y            (out_y),
    .escaped          (escaped),
    .escape_iteration (escape_iteration),
    .done             (done)
  );

endmodule
`default_nettype wire

// ===== sv/jeti_ctrl.sv =====
// Sequencer that steps one pixel through mapping, setup and the orbit loop.
`default_nettype none
module jeti_ctrl import jeti_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.mul_sel     = MUL_Z;
    cmd.kind        = RES_BOUNDED;
    busy            = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.mul_sel = MUL_MAP;
        state_next  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.mul_sel = MUL_KI;
        cmd.load_z  = 1'b1;
        state_next  = ST_RADIUS;
      end
      ST_RADIUS: begin
        cmd.load_radius = 1'b1;
        state_next      = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The squares on hand belong to the current z, so the magnitude test
        // covers the previous iteration before this one is applied.
        if (!status.first && status.mag_over) begin
          cmd.finish = 1'b1;
          cmd.kind   = RES_ESC_PREV;
          state_next = ST_IDLE;
        end else if (status.last) begin
          cmd.finish = 1'b1;
          cmd.kind   = RES_BOUNDED;
          state_next = ST_IDLE;
        end else if (status.overflow) begin
          cmd.finish = 1'b1;
          cmd.kind   = RES_ESC_NOW;
          state_next = ST_IDLE;
        end else begin
          cmd.update_z = 1'b1;
          state_next   = ST_MULT;
        end
      end
      ST_MULT: begin
        state_next = ST_UPDATE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/jeti_datapath.sv =====
// Coordinate mapping, complex square-add, escape test and result registers.
`default_nettype none
module jeti_datapath import jeti_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  input  wire logic [PIXEL_BITS-1:0]   pixel_x,
  input  wire logic [PIXEL_BITS-1:0]   pixel_y,
  input  wire logic                    mode,
  input  wire logic [LIMIT_W-1:0]      max_iterations,
  input  wire logic signed [VAL_W-1:0] const_real,
  input  wire logic signed [VAL_W-1:0] const_imag,
  input  wire logic signed [VAL_W-1:0] left_edge,
  input  wire logic [STEP_W-1:0]       column_step,
  input  wire logic signed [VAL_W-1:0] top_edge,
  input  wire logic [STEP_W-1:0]       row_step,
  output logic [PIXEL_BITS-1:0]        out_x,
  output logic [PIXEL_BITS-1:0]        out_y,
  output logic                         escaped,
  output logic [ITER_BITS-1:0]         escape_iteration,
  output logic                         done
);

  localparam int MUL_W  = VAL_W + 1;
  localparam int MUL_PW = 2 * MUL_W;
  // Squared radius of 2 at 2*FRAC_BITS fraction bits, or all ones if it does not fit.
  localparam logic [PROD_W-1:0] FOUR_SQ =
    (2 * FRAC_BITS + 2 < PROD_W) ? (PROD_W'(4) << (2 * FRAC_BITS)) : '1;

  logic [PIXEL_BITS-1:0]   px;
  logic [PIXEL_BITS-1:0]   py;
  logic signed [VAL_W-1:0] zr;
  logic signed [VAL_W-1:0] zi;
  logic signed [VAL_W-1:0] cr;
  logic signed [VAL_W-1:0] ci;
  logic [PROD_W-1:0]       kr2;
  logic [PROD_W-1:0]       r_sq;
  logic [LIMIT_W-1:0]      count;
  logic [LIMIT_W-1:0]      esc_idx;

  logic signed [MUL_W-1:0]  a0, b0, a1, b1, a2, b2;
  logic signed [MUL_PW-1:0] m0, m1, m2;
  logic signed [PROD_W-1:0] p0, p1, p2;

  logic signed [SAT_W-1:0]  re_wide;
  logic signed [SAT_W-1:0]  im_wide;
  logic signed [VAL_W-1:0]  re;
  logic signed [VAL_W-1:0]  im;
  logic signed [SAT_W-1:0]  nr_wide;
  logic signed [SAT_W-1:0]  ni_wide;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rad_sum;

  // Three shared multipliers; the operand set follows the sequencer step.
  always_comb begin
    case (cmd.mul_sel)
      MUL_MAP, MUL_KI: begin
        a0 = $signed(MUL_W'(px));
        b0 = $signed(MUL_W'(column_step));
        a1 = $signed(MUL_W'(py));
        b1 = $signed(MUL_W'(row_step));
        if (cmd.mul_sel == MUL_KI) begin
          a2 = MUL_W'(const_imag);
          b2 = MUL_W'(const_imag);
        end else begin
          a2 = MUL_W'(const_real);
          b2 = MUL_W'(const_real);
        end
      end
      default: begin
        a0 = MUL_W'(zr);
        b0 = MUL_W'(zr);
        a1 = MUL_W'(zi);
        b1 = MUL_W'(zi);
        a2 = MUL_W'(zr);
        b2 = MUL_W'(zi);
      end
    endcase
  end

  assign m0 = a0 * b0;
  assign m1 = a1 * b1;
  assign m2 = a2 * b2;

  always_ff @(posedge clk) begin
    p0 <= m0[PROD_W-1:0];
    p1 <= m1[PROD_W-1:0];
    p2 <= m2[PROD_W-1:0];
  end

  assign re_wide = SAT_W'(left_edge) + SAT_W'(p0);
  assign im_wide = SAT_W'(top_edge) - SAT_W'(p1);
  assign re      = sat_val(re_wide);
  assign im      = sat_val(im_wide);

  // Arithmetic right shifts round toward minus infinity.
  assign nr_wide = ((SAT_W'(p0) - SAT_W'(p1)) >>> FRAC_BITS) + SAT_W'(cr);
  assign ni_wide = (SAT_W'(p2) >>> (FRAC_BITS - 1)) + SAT_W'(ci);

  assign mag     = $unsigned(p0) + $unsigned(p1);
  assign rad_sum = kr2 + $unsigned(p2);

  assign status.first    = (count == '0);
  assign status.last     = (count == max_iterations);
  assign status.mag_over = (mag > r_sq);
  assign status.overflow = sat_ovf(nr_wide) || sat_ovf(ni_wide);

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.load_z) begin
      kr2 <= $unsigned(p2);
      if (mode) begin
        zr <= const_real;
        zi <= const_imag;
        cr <= re;
        ci <= im;
      end else begin
        zr <= re;
        zi <= im;
        cr <= const_real;
        ci <= const_imag;
      end
    end
    if (cmd.load_radius) begin
      r_sq <= (rad_sum < FOUR_SQ) ? FOUR_SQ : rad_sum;
    end
    if (cmd.update_z) begin
      zr <= sat_val(nr_wide);
      zi <= sat_val(ni_wide);
    end
    if (cmd.finish) begin
      out_x   <= px;
      out_y   <= py;
      escaped <= (cmd.kind != RES_BOUNDED);
      case (cmd.kind)
        RES_ESC_PREV: esc_idx <= count - LIMIT_W'(1);
        RES_ESC_NOW:  esc_idx <= count;
        default:      esc_idx <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load_pixel) begin
        count <= '0;
      end else if (cmd.update_z) begin
        count <= count + LIMIT_W'(1);
      end
    end
  end

  assign escape_iteration = ITER_BITS'(esc_idx);

endmodule
`default_nettype wire

// ===== sv/jeti_checker.sv =====
// Port-level checker of the escape-time iterator and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module jeti_checker #(
  parameter int ITER_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic                 escaped,
  input wire logic [ITER_BITS-1:0] escape_iteration
);

  `ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_NEXT(a_done_after_busy, !busy, !done, "result word without a pixel in work")
  `ASSERT_SAME(a_done_when_free, done, !busy, "busy still high while result word shown")
  `ASSERT_NEXT(a_done_single, done, !done, "result word strobed twice")
  `ASSERT_SAME(a_bounded_zero, done && !escaped, escape_iteration == '0,
               "bounded pixel reported a nonzero iteration")

endmodule

bind julia_escape_time_iterator jeti_checker #(
  .ITER_BITS (ITER_BITS)
) u_jeti_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .escaped          (escaped),
  .escape_iteration (escape_iteration)
);
`default_nettype wire

// ===== test/tb_julia_escape_time_iterator.sv =====
// Self-checking testbench for the Julia and parameter-plane escape-time iterator.
`timescale 1ns / 100ps
module tb_julia_escape_time_iterator;
  import jeti_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int PIX_W = PIXEL_BITS_DEF;
  localparam int ITR_W = ITER_BITS_DEF;
  localparam longint unsigned RADIUS_FLOOR = 64'd4 << (2 * FRAC);

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             esc;
    logic [ITR_W-1:0] iter;
  } orbit_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [PIX_W-1:0] pixel_x = '0;
  logic [PIX_W-1:0] pixel_y = '0;
  logic             cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [VAL_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  logic [PIX_W-1:0] out_x;
  logic [PIX_W-1:0] out_y;
  logic             escaped;
  logic [ITR_W-1:0] escape_iteration;

  // Copy of the register file as the block should hold it.
  logic             view_mode = 1'b0;
  logic [LIMIT_W-1:0] iter_limit = LIMIT_RESET;
  logic [VAL_W-1:0] seed_re = '0;
  logic [VAL_W-1:0] seed_im = '0;
  logic [VAL_W-1:0] left_q = '0;
  logic [STEP_W-1:0] col_step_q = '0;
  logic [VAL_W-1:0] top_q = '0;
  logic [STEP_W-1:0] row_step_q = '0;

  pixel_t        pending_pixels[$];
  orbit_result_t results_due[$];

  int  idle_odds = 0;
  bit  quiet_tail = 1'b0;
  int  hold_off = 0;
  int  mismatches = 0;
  int  pixels_sent = 0;
  int  escapes_seen = 0;
  int  bounded_seen = 0;
  int  deepest_escape = 0;
  int  settings_used = 1;

  julia_escape_time_iterator u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .out_x            (out_x),
    .out_y            (out_y),
    .escaped          (escaped),
    .escape_iteration (escape_iteration)
  );

  always #4 clk = ~clk;

  function automatic longint clip32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned mod_sq(input longint a, input longint b);
    return $unsigned(a * a) + $unsigned(b * b);
  endfunction

  // Maps the pixel to the plane and runs the orbit under the current settings.
  function automatic orbit_result_t trace_orbit(input logic [PIX_W-1:0] px,
                                                input logic [PIX_W-1:0] py);
    longint re, im, kr, ki, zr, zi, cr, ci, zr_next, zi_next;
    longint unsigned radius_sq;
    bit ovf;
    orbit_result_t r;
    ovf = 1'b0;
    re = clip32(longint'($signed(left_q)) + longint'(px) * longint'(col_step_q), ovf);
    im = clip32(longint'($signed(top_q)) - longint'(py) * longint'(row_step_q), ovf);
    kr = longint'($signed(seed_re));
    ki = longint'($signed(seed_im));
    if (view_mode) begin
      zr = kr; zi = ki; cr = re; ci = im;
    end else begin
      zr = re; zi = im; cr = kr; ci = ki;
    end
    radius_sq = mod_sq(kr, ki);
    if (radius_sq < RADIUS_FLOOR) radius_sq = RADIUS_FLOOR;
    r.x = px;
    r.y = py;
    r.esc = 1'b0;
    r.iter = '0;
    for (int unsigned i = 0; i < iter_limit; i++) begin
      ovf = 1'b0;
      zr_next = ((zr * zr - zi * zi) >>> FRAC) + cr;
      zi_next = ((zr * zi) >>> (FRAC - 1)) + ci;
      zr = clip32(zr_next, ovf);
      zi = clip32(zi_next, ovf);
      if (ovf || mod_sq(zr, zi) > radius_sq) begin
        r.esc = 1'b1;
        r.iter = i[ITR_W-1:0];
        break;
      end
    end
    return r;
  endfunction

  function automatic int fix(input real v);
    return int'(v * (2.0 ** FRAC));
  endfunction

  function automatic int rand_fix(input real lo, input real hi);
    return fix(lo) + int'($urandom_range(0, fix(hi) - fix(lo)));
  endfunction

  // Pixel driver: holds start until the word is taken, with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_off = 0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(trace_orbit(pixel_x, pixel_y));
        pending_pixels.delete(0);
        pixels_sent++;
      end
      if (start && busy) begin
        // The word is still waiting for the block.
      end else if (hold_off > 0) begin
        hold_off--;
        start <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
        start <= 1'b0;
      end else if (!quiet_tail && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        hold_off = $urandom_range(0, 6);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        pixel_x <= pending_pixels[0].x;
        pixel_y <= pending_pixels[0].y;
      end
    end
  end

  // Result monitor: done marks a word that must be taken in this very cycle.
  always @(posedge clk) begin
    orbit_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: x=%0d y=%0d escaped=%0d iteration=%0d",
                   out_x, out_y, escaped, escape_iteration);
      end else begin
        want = results_due.pop_front();
        if (out_x !== want.x || out_y !== want.y || escaped !== want.esc ||
            escape_iteration !== want.iter) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected x=%0d y=%0d escaped=%0d iteration=%0d, got x=%0d y=%0d escaped=%0d iteration=%0d",
                     want.x, want.y, want.esc, want.iter,
                     out_x, out_y, escaped, escape_iteration);
        end
        if (want.esc) begin
          escapes_seen++;
          if (int'(want.iter) > deepest_escape) deepest_escape = want.iter;
        end else begin
          bounded_seen++;
        end
      end
    end
  end

  task automatic queue_pixel(input int x, input int y);
    pixel_t p;
    p.x = x[PIX_W-1:0];
    p.y = y[PIX_W-1:0];
    pending_pixels.push_back(p);
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || results_due.size() != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MODE:           view_mode = data[0];
      REG_MAX_ITERATIONS: iter_limit = data[LIMIT_W-1:0];
      REG_CONST_REAL:     seed_re = data;
      REG_CONST_IMAG:     seed_im = data;
      REG_LEFT_EDGE:      left_q = data;
      REG_COLUMN_STEP:    col_step_q = data[STEP_W-1:0];
      REG_TOP_EDGE:       top_q = data;
      REG_ROW_STEP:       row_step_q = data[STEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits for the block to go quiet, then rewrites every register.
  task automatic set_view(input logic [31:0] mode_w, input logic [31:0] limit_w,
                          input logic [31:0] kr, input logic [31:0] ki,
                          input logic [31:0] lft, input logic [31:0] cstep,
                          input logic [31:0] tp, input logic [31:0] rstep);
    drain();
    write_reg(REG_MODE, mode_w);
    write_reg(REG_MAX_ITERATIONS, limit_w);
    write_reg(REG_CONST_REAL, kr);
    write_reg(REG_CONST_IMAG, ki);
    write_reg(REG_LEFT_EDGE, lft);
    write_reg(REG_COLUMN_STEP, cstep);
    write_reg(REG_TOP_EDGE, tp);
    write_reg(REG_ROW_STEP, rstep);
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] mode_w, lim_w, kr, ki, lft, cst, tp, rs;
    int n_items;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_odds = 3;

    // Reset settings: everything maps to the origin and stays bounded.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);

    // Julia plane over a 4 by 4 window: corners, center and two inner pixels.
    set_view(0, 64, fix(-0.8), fix(0.156), fix(-2.0), 262144, fix(2.0), 262144);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(4095, 4095);
    queue_pixel(2048, 2048);
    queue_pixel(1536, 1700);
    queue_pixel(2600, 1900);

    // Parameter plane; pixel (0, 2048) is c = -2, which sits exactly on the radius.
    set_view(32'hFFFF_FFFF, 100, 0, 0, fix(-2.0), 196608, fix(1.5), 196608);
    queue_pixel(0, 0);
    queue_pixel(2730, 2048);
    queue_pixel(0, 2048);
    queue_pixel(4095, 4095);

    // A constant of magnitude 3 widens the escape radius; far pixels saturate.
    set_view(1, 32, fix(3.0), 0, 32'h8000_0000, 32'h0100_0000, 0, 32'h0100_0000);
    queue_pixel(0, 0);
    queue_pixel(16, 0);
    queue_pixel(4095, 4095);

    // Most negative constant and full-scale steps: orbit overflow and saturation.
    set_view(0, 8, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFF0, 32'hFFFF_FFFF,
             32'h8000_0010, 32'h7FFF_FFFF);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(4095, 4095);

    // A zero iteration limit runs no step at all.
    set_view(0, 32'hABCD_0000, fix(0.3), fix(-0.5), fix(-1.0), 4096, fix(1.0), 4096);
    queue_pixel(5, 7);
    queue_pixel(4095, 0);

    // Largest limit on a fixed point at the origin.
    set_view(0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    queue_pixel(0, 0);

    for (int p = 0; p < 22; p++) begin
      quiet_tail = (p >= 19);
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      n_items = 50;
      if (p == 5) begin
        // Largest limit, but every pixel starts far outside the radius.
        n_items = 40;
        mode_w = 0;
        lim_w = 32'h0000_FFFF;
        kr = rand_fix(-1.2, 1.2);
        ki = rand_fix(-1.2, 1.2);
        lft = fix(2.5);
        cst = $urandom_range(1, 1 << 18);
        tp = rand_fix(-2.0, 2.0);
        rs = $urandom_range(1, 1 << 18);
      end else if (p == 11) begin
        // Long orbits near the boundary of a connected Julia set.
        n_items = 20;
        mode_w = 0;
        lim_w = 2000;
        kr = fix(-0.8);
        ki = fix(0.156);
        lft = fix(-1.6);
        cst = 1 << 16;
        tp = fix(0.5);
        rs = 1 << 16;
      end else begin
        mode_w = {$urandom_range(0, 3) == 0 ? 31'($urandom) : 31'd0, 1'($urandom)};
        lim_w = {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
                 16'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 40)
                                                  : $urandom_range(41, 200))};
        if ($urandom_range(0, 9) < 7) begin
          kr = rand_fix(-1.2, 1.2);
          ki = rand_fix(-1.2, 1.2);
        end else begin
          kr = $urandom;
          ki = $urandom;
        end
        if ($urandom_range(0, 9) < 7) begin
          lft = rand_fix(-2.5, -0.5);
          cst = {1'($urandom), 31'($urandom_range(1, 1 << 18))};
          tp = rand_fix(0.5, 2.5);
          rs = {1'($urandom), 31'($urandom_range(1, 1 << 18))};
        end else begin
          lft = $urandom;
          cst = $urandom;
          tp = $urandom;
          rs = $urandom;
        end
      end
      set_view(mode_w, lim_w, kr, ki, lft, cst, tp, rs);
      repeat (n_items) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end

    while (pending_pixels.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d pixels under %0d register settings in both planes.",
             pixels_sent, settings_used);
    $display("%0d orbits escaped (deepest at iteration %0d), %0d stayed bounded.",
             escapes_seen, deepest_escape, bounded_seen);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_julia_escape_time_iterator: PASS");
    end else begin
      $display("tb_julia_escape_time_iterator: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d results still due.", results_due.size());
    $display("tb_julia_escape_time_iterator: FAIL");
    $finish;
  end

endmodule

// ===== julia_escape_time_iterator.f =====
+incdir+sv
sv/jeti_pkg.sv
sv/jeti_ctrl.sv
sv/jeti_datapath.sv
sv/julia_escape_time_iterator.sv
sv/jeti_checker.sv
test/tb_julia_escape_time_iterator.sv
